// ===== rtl/gds_pkg.sv =====
// Shared types, constants and the microcode ROM of the grid decomposition search.
package gds_pkg;

  localparam int SPLIT_W  = 11;
  localparam int FIELD_W  = 16;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 24;
  localparam int MAX_WORKERS = 1024;
  localparam int PC_W     = 4;

  localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
  localparam logic [PC_W-1:0] ST_SW   = 4'd1;
  localparam logic [PC_W-1:0] ST_WW   = 4'd2;
  localparam logic [PC_W-1:0] ST_SR   = 4'd3;
  localparam logic [PC_W-1:0] ST_WR   = 4'd4;
  localparam logic [PC_W-1:0] ST_SC   = 4'd5;
  localparam logic [PC_W-1:0] ST_WC   = 4'd6;
  localparam logic [PC_W-1:0] ST_BEST = 4'd7;
  localparam logic [PC_W-1:0] ST_NEXT = 4'd8;
  localparam logic [PC_W-1:0] ST_INC  = 4'd9;
  localparam logic [PC_W-1:0] ST_EMIT = 4'd10;

  typedef enum logic [1:0] {DIV_NONE, DIV_WR, DIV_ROWS, DIV_COLS} div_sel_e;
  typedef enum logic [1:0] {H_NONE, H_IN, H_DIV, H_OUT} hold_e;
  typedef enum logic [2:0] {ACT_NONE, ACT_LOAD, ACT_BEST, ACT_INC, ACT_EMIT} act_e;
  typedef enum logic [1:0] {CAP_NONE, CAP_C, CAP_QR, CAP_QC} cap_e;
  typedef enum logic [2:0] {B_NONE, B_ALWAYS, B_BAD, B_REM, B_LAST} br_e;

  typedef struct packed {
    div_sel_e        div_sel;
    hold_e           hold;
    act_e            act;
    cap_e            cap;
    br_e             br;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{DIV_NONE, H_NONE, ACT_NONE, CAP_NONE, B_NONE, ST_IDLE};
    unique case (pc)
      ST_IDLE: w = '{DIV_NONE, H_IN,   ACT_LOAD, CAP_NONE, B_BAD,    ST_EMIT};
      ST_SW:   w = '{DIV_WR,   H_NONE, ACT_NONE, CAP_NONE, B_NONE,   ST_IDLE};
      ST_WW:   w = '{DIV_NONE, H_DIV,  ACT_NONE, CAP_C,    B_REM,    ST_NEXT};
      ST_SR:   w = '{DIV_ROWS, H_NONE, ACT_NONE, CAP_NONE, B_NONE,   ST_IDLE};
      ST_WR:   w = '{DIV_NONE, H_DIV,  ACT_NONE, CAP_QR,   B_REM,    ST_NEXT};
      ST_SC:   w = '{DIV_COLS, H_NONE, ACT_NONE, CAP_NONE, B_NONE,   ST_IDLE};
      ST_WC:   w = '{DIV_NONE, H_DIV,  ACT_NONE, CAP_QC,   B_REM,    ST_NEXT};
      ST_BEST: w = '{DIV_NONE, H_NONE, ACT_BEST, CAP_NONE, B_NONE,   ST_IDLE};
      ST_NEXT: w = '{DIV_NONE, H_NONE, ACT_NONE, CAP_NONE, B_LAST,   ST_EMIT};
      ST_INC:  w = '{DIV_NONE, H_NONE, ACT_INC,  CAP_NONE, B_ALWAYS, ST_SW};
      ST_EMIT: w = '{DIV_NONE, H_OUT,  ACT_EMIT, CAP_NONE, B_ALWAYS, ST_IDLE};
      default: w = '{DIV_NONE, H_NONE, ACT_NONE, CAP_NONE, B_ALWAYS, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/gds_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gds_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/grid_decomposition_search.sv =====
// Top level of the grid decomposition search: microcode sequencer and datapath.
//
// Takes one request (rows, columns, workers) and returns one result: the row split with
// the least block perimeter among those that divide workers and rows and whose column
// split divides the columns, ties going to the larger split. One request is in work at
// a time. The single shared divider, with a numerator W = max(DIM_BITS, 11) bits wide and
// DIM_BITS capped at 16, produces one quotient bit per cycle and is used three times for
// each split tried, fewer where an early remainder test fails; it sets the time that a
// request takes.
// Requests with zero workers or more than 1024 workers return at once with found low.
module grid_decomposition_search #(
  parameter int DIM_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // grid_rows[15:0], grid_cols[31:16], worker_count[42:32], zero fill
  input  logic [gds_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // row_splits[10:0], col_splits[21:11], zero fill
  output logic [gds_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  // found[0]
  output logic                          m_axis_tuser_o
);

  localparam int SW = gds_pkg::SPLIT_W;
  localparam int DW = (DIM_BITS < gds_pkg::FIELD_W) ? DIM_BITS : gds_pkg::FIELD_W;
  localparam int NW = (DW > SW) ? DW : SW;

  logic [gds_pkg::PC_W-1:0] pc_q, pc_d;
  gds_pkg::uword_t uw;

  logic [SW-1:0] w_q, r_q, c_q, best_r_q, best_c_q;
  logic [DW-1:0] rows_q, cols_q, qr_q, qc_q;
  logic [DW:0]   best_p_q, perim;
  logic          have_q;

  logic          m_valid_q;
  logic [SW-1:0] m_row_q, m_col_q;
  logic          m_found_q;

  logic          div_start, div_busy;
  logic [NW-1:0] div_num, div_quo;
  logic [SW-1:0] div_den, div_rem;

  logic          held, fire, take, in_bad;
  logic [SW-1:0] in_w;

  assign uw     = gds_pkg::ucode(pc_q);
  assign in_w   = s_axis_tdata_i[42:32];
  assign in_bad = (in_w == '0) || (32'(in_w) > 32'(gds_pkg::MAX_WORKERS));
  assign perim  = {1'b0, qr_q} + {1'b0, qc_q};

  always_comb begin
    unique case (uw.hold)
      gds_pkg::H_NONE: held = 1'b0;
      gds_pkg::H_IN:   held = !s_axis_tvalid_i;
      gds_pkg::H_DIV:  held = div_busy;
      gds_pkg::H_OUT:  held = m_valid_q && !m_axis_tready_i;
      default:         held = 1'b0;
    endcase
    fire = !held;
    unique case (uw.br)
      gds_pkg::B_NONE:   take = 1'b0;
      gds_pkg::B_ALWAYS: take = 1'b1;
      gds_pkg::B_BAD:    take = in_bad;
      gds_pkg::B_REM:    take = div_rem != '0;
      gds_pkg::B_LAST:   take = r_q == w_q;
      default:           take = 1'b0;
    endcase
    if (held) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_comb begin
    div_start = 1'b1;
    unique case (uw.div_sel)
      gds_pkg::DIV_NONE: begin
        div_start = 1'b0;
        div_num   = NW'(w_q);
        div_den   = r_q;
      end
      gds_pkg::DIV_WR: begin
        div_num = NW'(w_q);
        div_den = r_q;
      end
      gds_pkg::DIV_ROWS: begin
        div_num = NW'(rows_q);
        div_den = r_q;
      end
      gds_pkg::DIV_COLS: begin
        div_num = NW'(cols_q);
        div_den = c_q;
      end
      default: begin
        div_start = 1'b0;
        div_num   = NW'(w_q);
        div_den   = r_q;
      end
    endcase
  end

  gds_div #(
    .NUM_W(NW),
    .DEN_W(SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= gds_pkg::ST_IDLE;
      have_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (fire && uw.act == gds_pkg::ACT_LOAD) begin
        have_q <= 1'b0;
      end else if (fire && uw.act == gds_pkg::ACT_BEST) begin
        have_q <= 1'b1;
      end
      if (fire && uw.act == gds_pkg::ACT_EMIT) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      unique case (uw.act)
        gds_pkg::ACT_LOAD: begin
          rows_q <= s_axis_tdata_i[DW-1:0];
          cols_q <= s_axis_tdata_i[16+DW-1:16];
          w_q    <= in_w;
          r_q    <= SW'(1);
        end
        gds_pkg::ACT_BEST: begin
          if (!have_q || perim <= best_p_q) begin
            best_p_q <= perim;
            best_r_q <= r_q;
            best_c_q <= c_q;
          end
        end
        gds_pkg::ACT_INC: r_q <= r_q + 1'b1;
        gds_pkg::ACT_EMIT: begin
          m_row_q   <= have_q ? best_r_q : '0;
          m_col_q   <= have_q ? best_c_q : '0;
          m_found_q <= have_q;
        end
        gds_pkg::ACT_NONE: ;
        default: ;
      endcase
      unique case (uw.cap)
        gds_pkg::CAP_C:    c_q  <= div_quo[SW-1:0];
        gds_pkg::CAP_QR:   qr_q <= div_quo[DW-1:0];
        gds_pkg::CAP_QC:   qc_q <= div_quo[DW-1:0];
        gds_pkg::CAP_NONE: ;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = uw.act == gds_pkg::ACT_LOAD;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_col_q, m_row_q};
  assign m_axis_tuser_o  = m_found_q;

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_found_q) |-> (m_row_q != '0 && m_col_q != '0))
    else $error("found result with zero split");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_found_q) |-> (m_row_q == '0 && m_col_q == '0))
    else $error("empty result with nonzero split");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have_q && pc_q != gds_pkg::ST_IDLE) |-> (best_r_q != '0 && best_r_q <= w_q))
    else $error("best split outside worker range");

  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (pc_q == gds_pkg::ST_SW || pc_q == gds_pkg::ST_EMIT))
    else $error("bad step after request load");

endmodule

// ===== bench/grid_decomposition_search_test.sv =====
// Self-checking testbench for grid_decomposition_search: directed table, then random requests.
module grid_decomposition_search_test;

  localparam int SPLIT_W     = gds_pkg::SPLIT_W;
  localparam int FIELD_W     = gds_pkg::FIELD_W;
  localparam int S_DATA_W    = gds_pkg::S_DATA_W;
  localparam int M_DATA_W    = gds_pkg::M_DATA_W;
  localparam int MAX_WORKERS = gds_pkg::MAX_WORKERS;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RAND_PER_PHASE = 25;
  localparam int unsigned DIR_ROWS = 20;

  typedef struct packed {
    logic [SPLIT_W-1:0] row_splits;
    logic [SPLIT_W-1:0] col_splits;
    logic               found;
  } split_t;

  typedef struct packed {
    logic [FIELD_W-1:0] rows;
    logic [FIELD_W-1:0] cols;
    logic [SPLIT_W-1:0] workers;
    logic               typed;
    split_t             known;
  } req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  split_t      pending_splits [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;
  req_t        dir_tab [DIR_ROWS];

  grid_decomposition_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // least-perimeter split, ties to the larger row split
  function automatic split_t best_split(input logic [FIELD_W-1:0] rows_in,
                                        input logic [FIELD_W-1:0] cols_in,
                                        input logic [SPLIT_W-1:0] workers_in);
    split_t      res;
    int unsigned rows, cols, workers, r, c, perim, best_perim;
    bit          have;
    res = '0;
    have = 1'b0;
    best_perim = 0;
    rows = rows_in;
    cols = cols_in;
    workers = workers_in;
    if (workers <= MAX_WORKERS) begin
      for (r = 1; r <= workers; r++) begin
        if ((workers % r) == 0 && (rows % r) == 0) begin
          c = workers / r;
          if ((cols % c) == 0) begin
            perim = rows / r + cols / c;
            if (!have || perim <= best_perim) begin
              best_perim = perim;
              res.row_splits = r[SPLIT_W-1:0];
              res.col_splits = c[SPLIT_W-1:0];
              res.found = 1'b1;
              have = 1'b1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic req_t rand_req();
    req_t        rq;
    int unsigned pick, w;
    rq = '0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      w = $urandom_range(2047, 1025);
    end else if (pick < 13) begin
      w = $urandom_range(1024, 65);
    end else begin
      w = $urandom_range(48, 1);
    end
    rq.workers = w[SPLIT_W-1:0];
    if (w <= MAX_WORKERS && $urandom_range(99) < 65) begin
      rq.rows = FIELD_W'(w * $urandom_range(65535 / w, 0));
      rq.cols = FIELD_W'(w * $urandom_range(65535 / w, 0));
    end else begin
      rq.rows = FIELD_W'($urandom);
      rq.cols = FIELD_W'($urandom);
    end
    return rq;
  endfunction

  task automatic send_req(input req_t rq);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'b0, rq.workers, rq.cols, rq.rows};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (rq.typed) begin
      pending_splits.push_back(rq.known);
    end else begin
      pending_splits.push_back(best_split(rq.rows, rq.cols, rq.workers));
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_splits.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    split_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.row_splits = m_axis_tdata_o[10:0];
        got.col_splits = m_axis_tdata_o[21:11];
        got.found = m_axis_tuser_o;
        if (pending_splits.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction rows=%0d cols=%0d found=%0b", $time,
                   got.row_splits, got.col_splits, got.found);
        end else begin
          want = pending_splits.pop_front();
          if (got.row_splits !== want.row_splits) begin
            mismatches++;
            $display("%0t: row_splits expected %0d actual %0d", $time,
                     want.row_splits, got.row_splits);
          end
          if (got.col_splits !== want.col_splits) begin
            mismatches++;
            $display("%0t: col_splits expected %0d actual %0d", $time,
                     want.col_splits, got.col_splits);
          end
          if (got.found !== want.found) begin
            mismatches++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
          end
        end
      end
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 20000;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int unsigned i, ph;
    dir_tab = '{
      '{16'd1,     16'd1,     11'd1,    1'b1, '{11'd1,    11'd1, 1'b1}},
      '{16'd65535, 16'd65535, 11'd1,    1'b1, '{11'd1,    11'd1, 1'b1}},
      '{16'd100,   16'd100,   11'd0,    1'b1, '{11'd0,    11'd0, 1'b0}},
      '{16'd100,   16'd100,   11'd1025, 1'b1, '{11'd0,    11'd0, 1'b0}},
      '{16'd65535, 16'd65535, 11'd2047, 1'b1, '{11'd0,    11'd0, 1'b0}},
      '{16'd0,     16'd0,     11'd1024, 1'b1, '{11'd1024, 11'd1, 1'b1}},
      '{16'd0,     16'd0,     11'd1,    1'b1, '{11'd1,    11'd1, 1'b1}},
      '{16'd0,     16'd12,    11'd4,    1'b0, '0},
      '{16'd12,    16'd0,     11'd4,    1'b0, '0},
      '{16'd1024,  16'd1024,  11'd1024, 1'b0, '0},
      '{16'd65535, 16'd65535, 11'd1024, 1'b0, '0},
      '{16'd7,     16'd1,     11'd7,    1'b0, '0},
      '{16'd1,     16'd7,     11'd7,    1'b0, '0},
      '{16'd13,    16'd17,    11'd6,    1'b0, '0},
      '{16'd8,     16'd8,     11'd4,    1'b0, '0},
      '{16'd6,     16'd6,     11'd2,    1'b0, '0},
      '{16'd48,    16'd64,    11'd12,   1'b0, '0},
      '{16'd65534, 16'd32768, 11'd1022, 1'b0, '0},
      '{16'd21845, 16'd43690, 11'd341,  1'b0, '0},
      '{16'd43690, 16'd21845, 11'd682,  1'b0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++) send_req(dir_tab[i]);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 80; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 80; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      for (i = 0; i < RAND_PER_PHASE; i++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 0 && i == 10) hold_go = 1'b1;
        send_req(rand_req());
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gds_pkg.sv
rtl/gds_div.sv
rtl/grid_decomposition_search.sv
bench/grid_decomposition_search_test.sv
